// ----- rtl/core/crot_pkg.sv -----
// Shared types and constants for the circle / rectangle overlap test.
package crot_pkg;

    // Shape pairing carried by each item
    typedef enum logic [1:0] {
        MODE_CC = 2'd0,  // circle against circle
        MODE_RR = 2'd1,  // rectangle against rectangle
        MODE_CR = 2'd2,  // first circle, second rectangle
        MODE_RC = 2'd3   // first rectangle, second circle
    } mode_t;

    // Guard bits added above the coordinate width for doubled centres,
    // edges and edges grown by a radius
    localparam int EXT_GUARD_BITS = 4;

    // Decision from the geometry stage to the distance stage
    typedef struct packed {
        logic use_dist;  // decide by squared distance against squared radius
        logic flag_hit;  // decision when no distance test is needed
    } ctl_t;

endpackage

// ----- rtl/core/crot_geom.sv -----
// Edge math: picks the circle and rectangle roles, derives edges, band tests
// and the rectangle result, and selects the deltas and radius for the
// squared distance test.
module crot_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic [1:0]                                     mode,
    input  logic signed [COORD_BITS-1:0]                   first_pos_x,
    input  logic signed [COORD_BITS-1:0]                   first_pos_y,
    input  logic [COORD_BITS-2:0]                          first_size_x,
    input  logic [COORD_BITS-2:0]                          first_size_y,
    input  logic signed [COORD_BITS-1:0]                   second_pos_x,
    input  logic signed [COORD_BITS-1:0]                   second_pos_y,
    input  logic [COORD_BITS-2:0]                          second_size_x,
    input  logic [COORD_BITS-2:0]                          second_size_y,
    output crot_pkg::ctl_t                                 ctl,
    output logic signed [COORD_BITS+crot_pkg::EXT_GUARD_BITS-1:0] dist_x,
    output logic signed [COORD_BITS+crot_pkg::EXT_GUARD_BITS-1:0] dist_y,
    output logic [COORD_BITS-1:0]                          radius
);

    localparam int EW = COORD_BITS + crot_pkg::EXT_GUARD_BITS;
    localparam int PAD_POS = EW - COORD_BITS - 1;
    localparam int PAD_SIZE = EW - COORD_BITS + 1;

    logic signed [EW-1:0] ax, ay, ahx, ahy;
    logic signed [EW-1:0] bx, by, bhx, bhy;
    logic signed [EW-1:0] cx, cy, rad;
    logic signed [EW-1:0] rx, ry, rhx, rhy;
    logic signed [EW-1:0] left, right, top, bottom;
    logic signed [EW-1:0] edge_x, edge_y;
    logic                 in_x, in_y, band_hit, rr_hit;
    logic                 circ_second;
    crot_pkg::mode_t      m;

    // Doubled centres (one more fraction bit); half sizes are the sizes
    assign ax  = {{PAD_POS{first_pos_x[COORD_BITS-1]}}, first_pos_x, 1'b0};
    assign ay  = {{PAD_POS{first_pos_y[COORD_BITS-1]}}, first_pos_y, 1'b0};
    assign bx  = {{PAD_POS{second_pos_x[COORD_BITS-1]}}, second_pos_x, 1'b0};
    assign by  = {{PAD_POS{second_pos_y[COORD_BITS-1]}}, second_pos_y, 1'b0};
    assign ahx = {{PAD_SIZE{1'b0}}, first_size_x};
    assign ahy = {{PAD_SIZE{1'b0}}, first_size_y};
    assign bhx = {{PAD_SIZE{1'b0}}, second_size_x};
    assign bhy = {{PAD_SIZE{1'b0}}, second_size_y};

    assign m = crot_pkg::mode_t'(mode);
    assign circ_second = (m == crot_pkg::MODE_RC);

    // Role selection for the mixed modes
    assign cx  = circ_second ? bx  : ax;
    assign cy  = circ_second ? by  : ay;
    assign rad = circ_second ? bhx : ahx;
    assign rx  = circ_second ? ax  : bx;
    assign ry  = circ_second ? ay  : by;
    assign rhx = circ_second ? ahx : bhx;
    assign rhy = circ_second ? ahy : bhy;

    // Rectangle edges
    assign left   = rx - rhx;
    assign right  = rx + rhx;
    assign top    = ry - rhy;
    assign bottom = ry + rhy;

    // Centre in a band (edges included), and inside the grown rectangle
    assign in_x = (left <= cx) && (cx <= right);
    assign in_y = (top <= cy) && (cy <= bottom);
    assign band_hit = ((left - rad) < cx) && (cx < (right + rad)) &&
                      ((top - rad) < cy) && (cy < (bottom + rad));

    // Outside both bands the nearest corner decides
    assign edge_x = (cx < left) ? left : right;
    assign edge_y = (cy < top) ? top : bottom;

    // Rectangle against rectangle, all strict
    assign rr_hit = ((ax - ahx) < (bx + bhx)) && ((ay - ahy) < (by + bhy)) &&
                    ((bx - bhx) < (ax + ahx)) && ((by - bhy) < (ay + ahy));

    // Mode decode
    always_comb
    begin
        ctl.use_dist = 1'b0;
        ctl.flag_hit = 1'b0;
        dist_x = cx - edge_x;
        dist_y = cy - edge_y;
        radius = rad[COORD_BITS-1:0];
        unique case (m)
            crot_pkg::MODE_CC:
            begin
                ctl.use_dist = 1'b1;
                dist_x = ax - bx;
                dist_y = ay - by;
                radius = {1'b0, first_size_x} + {1'b0, second_size_x};
            end
            crot_pkg::MODE_RR:
            begin
                ctl.flag_hit = rr_hit;
            end
            default:
            begin
                ctl.use_dist = !(in_x || in_y);
                ctl.flag_hit = band_hit;
            end
        endcase
    end

endmodule

// ----- rtl/core/crot_dist.sv -----
// Squared distance test: dx^2 + dy^2 < r^2, or the geometry flag when no
// distance test applies.
module crot_dist #(
    parameter int COORD_BITS = 16
) (
    input  crot_pkg::ctl_t                                 ctl,
    input  logic signed [COORD_BITS+crot_pkg::EXT_GUARD_BITS-1:0] dist_x,
    input  logic signed [COORD_BITS+crot_pkg::EXT_GUARD_BITS-1:0] dist_y,
    input  logic [COORD_BITS-1:0]                          radius,
    output logic                                           hit
);

    localparam int EW = COORD_BITS + crot_pkg::EXT_GUARD_BITS;
    localparam int SW = 2 * EW - 1;
    localparam int PAD_R = SW - 2 * COORD_BITS;

    logic signed [EW-1:0]       neg_x, neg_y;
    logic [EW-2:0]              mag_x, mag_y;
    logic [2*EW-3:0]            sq_x, sq_y;
    logic [2*COORD_BITS-1:0]    sq_r;
    logic [SW-1:0]              dist_sq;

    // Magnitudes; deltas never reach the most negative code
    assign neg_x = -dist_x;
    assign neg_y = -dist_y;
    assign mag_x = dist_x[EW-1] ? neg_x[EW-2:0] : dist_x[EW-2:0];
    assign mag_y = dist_y[EW-1] ? neg_y[EW-2:0] : dist_y[EW-2:0];

    // Squares and compare
    assign sq_x = mag_x * mag_x;
    assign sq_y = mag_y * mag_y;
    assign sq_r = radius * radius;
    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

    assign hit = ctl.use_dist ? (dist_sq < {{PAD_R{1'b0}}, sq_r}) : ctl.flag_hit;

endmodule

// ----- rtl/core/circle_rect_overlap_test_unit.sv -----
// Circle / rectangle overlap test.
// Input channel: item_valid / item_stall with mode and the two shapes
// (signed centres, unsigned sizes). An item is taken at a clock edge where
// item_valid is high and item_stall is low.
// Output channel: result_valid / result_stall with the hit flag; a result is
// taken where result_valid is high and result_stall is low.
// Each item passes an input register, one stage of edge math, squaring and
// compare, and a result register, which drives result_valid. Throughput is
// one item per cycle while the result register is not held by result_stall,
// set by the single registered pass with one squarer per axis and one for the
// radius.
// When result_stall holds the result register, one more item waits in the
// input register; item_stall rises only when both are full.
// Reset (rst_n low, asynchronous) empties both registers; result_valid and
// item_stall go low.
// COORD_BITS sets the centre width; sizes are COORD_BITS-1 bits.
module circle_rect_overlap_test_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic signed [COORD_BITS-1:0]  first_pos_x,
    input  logic signed [COORD_BITS-1:0]  first_pos_y,
    input  logic [COORD_BITS-2:0]         first_size_x,
    input  logic [COORD_BITS-2:0]         first_size_y,
    input  logic signed [COORD_BITS-1:0]  second_pos_x,
    input  logic signed [COORD_BITS-1:0]  second_pos_y,
    input  logic [COORD_BITS-2:0]         second_size_x,
    input  logic [COORD_BITS-2:0]         second_size_y,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          hit
);

    localparam int EW = COORD_BITS + crot_pkg::EXT_GUARD_BITS;

    logic                          in_valid_reg, in_valid_next;
    logic [1:0]                    mode_reg;
    logic signed [COORD_BITS-1:0]  apx_reg, apy_reg, bpx_reg, bpy_reg;
    logic [COORD_BITS-2:0]         asx_reg, asy_reg, bsx_reg, bsy_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          hit_reg;
    logic                          out_free, load_in, stage_hit;
    crot_pkg::ctl_t                ctl;
    logic signed [EW-1:0]          dist_x, dist_y;
    logic [COORD_BITS-1:0]         radius;

    // Handshake control
    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !out_free;
    assign load_in    = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_valid_reg || out_free)
        begin
            in_valid_next = item_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            mode_reg <= mode;
            apx_reg  <= first_pos_x;
            apy_reg  <= first_pos_y;
            asx_reg  <= first_size_x;
            asy_reg  <= first_size_y;
            bpx_reg  <= second_pos_x;
            bpy_reg  <= second_pos_y;
            bsx_reg  <= second_size_x;
            bsy_reg  <= second_size_y;
        end
    end

    // Geometry and distance test
    crot_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .mode          (mode_reg),
        .first_pos_x   (apx_reg),
        .first_pos_y   (apy_reg),
        .first_size_x  (asx_reg),
        .first_size_y  (asy_reg),
        .second_pos_x  (bpx_reg),
        .second_pos_y  (bpy_reg),
        .second_size_x (bsx_reg),
        .second_size_y (bsy_reg),
        .ctl           (ctl),
        .dist_x        (dist_x),
        .dist_y        (dist_y),
        .radius        (radius)
    );

    crot_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .ctl    (ctl),
        .dist_x (dist_x),
        .dist_y (dist_y),
        .radius (radius),
        .hit    (stage_hit)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            hit_reg <= stage_hit;
        end
    end

    assign result_valid = out_valid_reg;
    assign hit          = hit_reg;

endmodule
